// File: sv/usv_pkg.sv
package usv_pkg;

    localparam int CpWidth = 21;

    localparam logic [7:0] LeadTwoLo   = 8'hC2;
    localparam logic [7:0] LeadTwoHi   = 8'hDF;
    localparam logic [7:0] LeadThreeLo = 8'hE0;
    localparam logic [7:0] LeadThreeHi = 8'hEF;
    localparam logic [7:0] LeadFourLo  = 8'hF0;
    localparam logic [7:0] LeadFourHi  = 8'hF4;
    localparam logic [7:0] AsciiHi     = 8'h7F;
    localparam logic [7:0] ContMask    = 8'hC0;
    localparam logic [7:0] ContTag     = 8'h80;

    localparam logic [CpWidth-1:0] MinThree     = 21'h000800;
    localparam logic [CpWidth-1:0] MinFour      = 21'h010000;
    localparam logic [CpWidth-1:0] MaxCodePoint = 21'h10FFFF;
    localparam logic [CpWidth-1:0] SurrogateLo  = 21'h00D800;
    localparam logic [CpWidth-1:0] SurrogateHi  = 21'h00DFFF;

    typedef struct packed {
        logic [1:0]         pending;
        logic [1:0]         seq_len;
        logic [CpWidth-1:0] code_point;
        logic               failed;
    } t_state;

endpackage

// File: sv/usv_step.sv
module usv_step (
    input  usv_pkg::t_state i_state,
    input  logic [7:0]      i_data_byte,
    input  logic            i_last_byte,
    output usv_pkg::t_state o_state,
    output logic            o_string_valid
);

    usv_pkg::t_state n_work;
    logic [usv_pkg::CpWidth-1:0] n_cp;
    logic [1:0] n_pend;

    always_comb begin
        n_work = i_state;
        n_cp   = {i_state.code_point[usv_pkg::CpWidth-7:0], i_data_byte[5:0]};
        n_pend = i_state.pending - 2'd1;

        if (!i_state.failed) begin
            if (i_state.pending == 2'd0) begin
                // lead byte
                if (i_data_byte == 8'h00) begin
                    n_work.failed = 1'b1;
                end else if (i_data_byte <= usv_pkg::AsciiHi) begin
                    n_work.failed = 1'b0;
                end else if (i_data_byte >= usv_pkg::LeadTwoLo &&
                             i_data_byte <= usv_pkg::LeadTwoHi) begin
                    n_work.pending    = 2'd1;
                    n_work.seq_len    = 2'd1;
                    n_work.code_point = {16'd0, i_data_byte[4:0]};
                end else if (i_data_byte >= usv_pkg::LeadThreeLo &&
                             i_data_byte <= usv_pkg::LeadThreeHi) begin
                    n_work.pending    = 2'd2;
                    n_work.seq_len    = 2'd2;
                    n_work.code_point = {17'd0, i_data_byte[3:0]};
                end else if (i_data_byte >= usv_pkg::LeadFourLo &&
                             i_data_byte <= usv_pkg::LeadFourHi) begin
                    n_work.pending    = 2'd3;
                    n_work.seq_len    = 2'd3;
                    n_work.code_point = {18'd0, i_data_byte[2:0]};
                end else begin
                    n_work.failed = 1'b1;
                end
            end else begin
                // continuation byte
                if ((i_data_byte & usv_pkg::ContMask) != usv_pkg::ContTag) begin
                    n_work.failed = 1'b1;
                end else begin
                    n_work.code_point = n_cp;
                    n_work.pending    = n_pend;
                    if (n_pend == 2'd0) begin
                        if ((i_state.seq_len == 2'd2 && n_cp < usv_pkg::MinThree) ||
                            (i_state.seq_len == 2'd3 && n_cp < usv_pkg::MinFour) ||
                            (n_cp > usv_pkg::MaxCodePoint) ||
                            (n_cp >= usv_pkg::SurrogateLo &&
                             n_cp <= usv_pkg::SurrogateHi)) begin
                            n_work.failed = 1'b1;
                        end else begin
                            n_work.seq_len    = 2'd0;
                            n_work.code_point = '0;
                        end
                    end
                end
            end
        end

        // truncated sequence at the end also fails
        o_string_valid = !(n_work.failed || n_work.pending != 2'd0);

        if (i_last_byte) begin
            o_state = '0;
        end else begin
            o_state = n_work;
        end
    end

endmodule

// File: sv/utf8_stream_validator.sv
// Strict UTF-8 checker, one byte word per cycle.
// The last byte word is staged first; its verdict is then registered at the output.
// Throughput: one byte word per cycle sustained; input stalls only while a
// finished verdict waits and the next last byte is already staged.
// Reset: synchronous, active low; clears the staged word's valid flag, the
// scan state and the output valid flag.
module utf8_stream_validator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_string_valid
);

    logic            r_in_valid;
    logic [7:0]      r_byte;
    logic            r_last;
    usv_pkg::t_state r_state;
    usv_pkg::t_state n_state;
    logic            r_out_valid;
    logic            r_verdict;
    logic            n_verdict;
    logic            out_free;
    logic            advance;
    logic            accept;

    usv_step u_step (
        .i_state        (r_state),
        .i_data_byte    (r_byte),
        .i_last_byte    (r_last),
        .o_state        (n_state),
        .o_string_valid (n_verdict)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!r_last || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_last) begin
            r_verdict <= n_verdict;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_string_valid = r_verdict;

endmodule

// File: sv/usv_checker.sv
module usv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_data_byte,
    input logic       i_last_byte,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_string_valid
);

    // verdict held while the consumer stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_string_valid))
        else $error("verdict dropped or changed under stall");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // input only backs up behind a blocked verdict
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked verdict");

    a_leave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_out_valid) |-> $past(!i_out_stall))
        else $error("verdict vanished without being taken");

    // stalled input word stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=>
            i_in_valid && $stable(i_data_byte) && $stable(i_last_byte))
        else $error("input word changed under stall");

endmodule

bind utf8_stream_validator usv_checker u_usv_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_data_byte    (i_data_byte),
    .i_last_byte    (i_last_byte),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_string_valid (o_string_valid)
);
